>>> rtl/tpmd_pkg.sv
package tpmd_pkg;

  localparam int unsigned PwmW    = 8;
  localparam int unsigned PeriodW = 21;
  localparam int unsigned TmoW    = 16;

  localparam logic [PwmW-1:0] StopDuty = 8'd255;

  typedef enum logic {
    ActCommand = 1'b0,
    ActTick    = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    MotorCcw   = 2'd0,
    MotorCw    = 2'd1,
    MotorOff   = 2'd2,
    MotorBrake = 2'd3
  } motor_cmd_e;

  typedef struct packed {
    action_e                  action;
    motor_cmd_e               motor_cmd;
    logic [PwmW-1:0]          power;
    logic signed [TmoW-1:0]   timeout_ms;
  } cmd_t;

  typedef struct packed {
    logic                  dir_a_on;
    logic                  dir_b_on;
    logic                  pwm_level;
    logic [PwmW-1:0]       duty_now;
    logic [PeriodW-1:0]    ticks_left;
  } res_t;

  // decoded command, held between the input register and the state update
  typedef struct packed {
    action_e               action;
    motor_cmd_e            motor_cmd;
    logic [PwmW-1:0]       power;
    logic                  tmo_zero;
    logic [PeriodW-1:0]    periods;
  } stage_t;

endpackage

>>> rtl/tpmd_if.sv
interface tpmd_cmd_if;
  import tpmd_pkg::*;

  logic valid;
  logic ready;
  cmd_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tpmd_res_if;
  import tpmd_pkg::*;

  logic valid;
  logic ready;
  res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/timed_pwm_motor_drive_core.sv
// An accepted input passes the input register and then the result register before its result can transfer.
// Throughput: one item per cycle unless output stalls; the state update and result sit in a single register stage.
// Output backpressure stalls both stages; the input register keeps accepting while a slot is free.
// Reset (rst_ni low, asynchronous): PWM counter, duty, both enables and pending period count
// clear to zero, and both pipeline stages empty.
module timed_pwm_motor_drive_core
  import tpmd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  tpmd_cmd_if.sink   in_i,
  tpmd_res_if.source out_o
);

  logic   s1_valid;
  stage_t s1_stage;
  logic   s1_advance;

  tpmd_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_i.valid),
    .cmd_i     (in_i.data),
    .ready_o   (in_i.ready),
    .valid_o   (s1_valid),
    .stage_o   (s1_stage),
    .advance_i (s1_advance)
  );

  tpmd_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s1_valid),
    .stage_i   (s1_stage),
    .advance_o (s1_advance),
    .valid_o   (out_o.valid),
    .res_o     (out_o.data),
    .ready_i   (out_o.ready)
  );

endmodule

>>> rtl/tpmd_in_stage.sv
module tpmd_in_stage
  import tpmd_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  input  cmd_t   cmd_i,
  output logic   ready_o,
  output logic   valid_o,
  output stage_t stage_o,
  input  logic   advance_i
);

  logic   valid_q;
  stage_t stage_q;
  stage_t stage_d;
  logic   take;

  logic [TmoW-2:0]    raw;
  logic [PeriodW-1:0] raw_ext;

  assign ready_o = !valid_q || advance_i;
  assign take    = valid_i && ready_o;

  assign raw     = cmd_i.timeout_ms[TmoW-2:0];
  assign raw_ext = PeriodW'(raw);

  // t*62 + t/4 as (t<<6) - (t<<1) + (t>>2)
  always_comb begin
    stage_d.action    = cmd_i.action;
    stage_d.motor_cmd = cmd_i.motor_cmd;
    stage_d.power     = cmd_i.power;
    stage_d.tmo_zero  = (cmd_i.timeout_ms == '0);
    if (cmd_i.timeout_ms[TmoW-1]) begin
      stage_d.periods = '0;
    end else begin
      stage_d.periods = (raw_ext << 6) - (raw_ext << 1) + (raw_ext >> 2);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

>>> rtl/tpmd_core.sv
module tpmd_core
  import tpmd_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  input  stage_t stage_i,
  output logic   advance_o,
  output logic   valid_o,
  output res_t   res_o,
  input  logic   ready_i
);

  logic [PwmW-1:0]    cnt_q, cnt_d;
  logic [PwmW-1:0]    duty_q, duty_d;
  logic               dir_a_q, dir_a_d;
  logic               dir_b_q, dir_b_d;
  logic [PeriodW-1:0] left_q, left_d;
  logic               valid_q;
  res_t               res_q, res_d;

  assign advance_o = valid_i && (!valid_q || ready_i);

  always_comb begin
    cnt_d   = cnt_q;
    duty_d  = duty_q;
    dir_a_d = dir_a_q;
    dir_b_d = dir_b_q;
    left_d  = left_q;
    case (stage_i.action)
      ActTick: begin
        cnt_d = cnt_q + 1'b1;
        // wrap: count down a pending timeout, stop on expiry
        if (cnt_d == '0 && left_q != '0) begin
          left_d = left_q - 1'b1;
          if (left_d == '0) begin
            dir_a_d = 1'b0;
            dir_b_d = 1'b0;
            duty_d  = StopDuty;
          end
        end
      end
      ActCommand: begin
        cnt_d  = '0;
        left_d = stage_i.periods;
        if (stage_i.tmo_zero) begin
          dir_a_d = 1'b0;
          dir_b_d = 1'b0;
          duty_d  = StopDuty;
        end else begin
          case (stage_i.motor_cmd)
            MotorCcw: begin
              dir_a_d = 1'b1;
              dir_b_d = 1'b0;
              duty_d  = stage_i.power;
            end
            MotorCw: begin
              dir_a_d = 1'b0;
              dir_b_d = 1'b1;
              duty_d  = stage_i.power;
            end
            MotorOff: begin
              dir_a_d = 1'b0;
              dir_b_d = 1'b0;
              duty_d  = '0;
            end
            default: begin
              dir_a_d = 1'b0;
              dir_b_d = 1'b0;
              duty_d  = stage_i.power;
            end
          endcase
        end
      end
      default: begin
        cnt_d = cnt_q;
      end
    endcase

    res_d.dir_a_on   = dir_a_d;
    res_d.dir_b_on   = dir_b_d;
    res_d.pwm_level  = (cnt_d <= duty_d);
    res_d.duty_now   = duty_d;
    res_d.ticks_left = left_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      duty_q  <= '0;
      dir_a_q <= 1'b0;
      dir_b_q <= 1'b0;
      left_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      if (advance_o) begin
        cnt_q   <= cnt_d;
        duty_q  <= duty_d;
        dir_a_q <= dir_a_d;
        dir_b_q <= dir_b_d;
        left_q  <= left_d;
        valid_q <= 1'b1;
      end else if (ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o) begin
      res_q <= res_d;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

>>> bench/pwm_drive_checker.sv
module pwm_drive_checker
  import tpmd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  tpmd_cmd_if  cmd_i,
  tpmd_res_if  res_i,
  output int   outstanding_o,
  output int   failures_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // one millisecond of timeout is 62.25 PWM periods
  localparam logic [PeriodW-1:0] PeriodsPerMs = 21'd62;
  localparam int unsigned        MsFracShift  = 2;

  logic [PwmW-1:0]    pwm_cnt;
  logic [PwmW-1:0]    duty_q;
  logic               dir_a_q;
  logic               dir_b_q;
  logic [PeriodW-1:0] periods_q;

  res_t expected_q[$];
  res_t want;
  res_t got;
  bit   bad;
  int   err_cnt;

  assign failures_o = err_cnt;

  function automatic void stop_drive();
    dir_a_q = 1'b0;
    dir_b_q = 1'b0;
    duty_q  = StopDuty;
  endfunction

  function automatic res_t drive_step(input cmd_t item);
    res_t               r;
    logic [PeriodW-1:0] ms;
    ms = {{(PeriodW-TmoW){1'b0}}, item.timeout_ms};
    if (item.action == ActTick) begin
      pwm_cnt = pwm_cnt + 1'b1;
      // count down one period per wrap, stop on the last one
      if (pwm_cnt == '0 && periods_q != '0) begin
        periods_q = periods_q - 1'b1;
        if (periods_q == '0) stop_drive();
      end
    end else begin
      pwm_cnt = '0;
      if (item.timeout_ms == 0) begin
        periods_q = '0;
        stop_drive();
      end else begin
        periods_q = (item.timeout_ms < 0) ? '0 : ms * PeriodsPerMs + (ms >> MsFracShift);
        case (item.motor_cmd)
          MotorCcw: begin
            dir_a_q = 1'b1;
            dir_b_q = 1'b0;
            duty_q  = item.power;
          end
          MotorCw: begin
            dir_a_q = 1'b0;
            dir_b_q = 1'b1;
            duty_q  = item.power;
          end
          MotorOff: begin
            dir_a_q = 1'b0;
            dir_b_q = 1'b0;
            duty_q  = '0;
          end
          default: begin
            dir_a_q = 1'b0;
            dir_b_q = 1'b0;
            duty_q  = item.power;
          end
        endcase
      end
    end
    r.dir_a_on   = dir_a_q;
    r.dir_b_on   = dir_b_q;
    r.pwm_level  = (pwm_cnt <= duty_q);
    r.duty_now   = duty_q;
    r.ticks_left = periods_q;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pwm_cnt       = '0;
      duty_q        = '0;
      dir_a_q       = 1'b0;
      dir_b_q       = 1'b0;
      periods_q     = '0;
      outstanding_o <= 0;
    end else begin
      if (cmd_i.valid && cmd_i.ready) expected_q.push_back(drive_step(cmd_i.data));
      if (res_i.valid && res_i.ready) begin
        got = res_i.data;
        if (expected_q.size() == 0) begin
          $error("result transfer with no expected result: %p", got);
          err_cnt++;
        end else begin
          want = expected_q.pop_front();
          bad  = 1'b0;
          if (got.dir_a_on !== want.dir_a_on) begin
            $error("dir_a_on: expected %0d, actual %0d", want.dir_a_on, got.dir_a_on);
            bad = 1'b1;
          end
          if (got.dir_b_on !== want.dir_b_on) begin
            $error("dir_b_on: expected %0d, actual %0d", want.dir_b_on, got.dir_b_on);
            bad = 1'b1;
          end
          if (got.pwm_level !== want.pwm_level) begin
            $error("pwm_level: expected %0d, actual %0d", want.pwm_level, got.pwm_level);
            bad = 1'b1;
          end
          if (got.duty_now !== want.duty_now) begin
            $error("duty_now: expected %0d, actual %0d", want.duty_now, got.duty_now);
            bad = 1'b1;
          end
          if (got.ticks_left !== want.ticks_left) begin
            $error("ticks_left: expected %0d, actual %0d", want.ticks_left, got.ticks_left);
            bad = 1'b1;
          end
          if (bad) err_cnt++;
        end
      end
      outstanding_o <= expected_q.size();
    end
  end

endmodule

>>> bench/tb_timed_pwm_motor_drive_core.sv
module tb_timed_pwm_motor_drive_core
  import tpmd_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandomItems = 950;

  logic clk;
  logic rst_n;
  bit   calm;
  int   items_sent;
  int   outstanding;
  int   failures;
  int   stall_left;

  tpmd_cmd_if cmd_bus ();
  tpmd_res_if res_bus ();

  timed_pwm_motor_drive_core u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (cmd_bus),
    .out_o  (res_bus)
  );

  pwm_drive_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cmd_i         (cmd_bus),
    .res_i         (res_bus),
    .outstanding_o (outstanding),
    .failures_o    (failures)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic cmd_t command(input motor_cmd_e m, input logic [PwmW-1:0] p,
                                   input logic signed [TmoW-1:0] tmo);
    cmd_t c;
    c.action     = ActCommand;
    c.motor_cmd  = m;
    c.power      = p;
    c.timeout_ms = tmo;
    return c;
  endfunction

  // payload of a tick is don't-care, so fill it with noise
  function automatic cmd_t tick();
    cmd_t c;
    c.action     = ActTick;
    c.motor_cmd  = motor_cmd_e'($urandom_range(0, 3));
    c.power      = 8'($urandom);
    c.timeout_ms = 16'($urandom);
    return c;
  endfunction

  function automatic logic signed [TmoW-1:0] random_timeout();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return 16'h8000 | 16'($urandom);
    if (r < 30) return '0;
    if (r < 70) return 16'($urandom_range(1, 8));
    return 16'($urandom_range(1, 32767));
  endfunction

  task automatic send_item(input cmd_t item);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      cmd_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_bus.valid <= 1'b1;
    cmd_bus.data  <= item;
    do @(posedge clk); while (!cmd_bus.ready);
    items_sent++;
  endtask

  task automatic drain();
    cmd_bus.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // result side: random stalls, none started while calm
  initial begin
    res_bus.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        res_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        res_bus.ready <= 1'b1;
        if (!calm && $urandom_range(0, 99) < 15) stall_left = idle_cycles() + 1;
      end
    end
  end

  initial begin
    #40ms;
    $display("status: fail");
    $finish;
  end

  initial begin
    int r;
    int burst;
    rst_n         <= 1'b0;
    cmd_bus.valid <= 1'b0;
    cmd_bus.data  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(tick());
    send_item(command(MotorCcw, 8'd255, -16'sd1));
    send_item(tick());
    send_item(command(MotorCw, 8'd0, 16'sd32767));
    send_item(tick());
    send_item(command(MotorOff, 8'd200, 16'sd1));
    send_item(command(MotorBrake, 8'd128, -16'sd32768));
    send_item(command(MotorCcw, 8'd77, 16'sd0));
    send_item(tick());
    send_item(command(MotorCw, 8'd1, 16'sd4));
    send_item(command(MotorBrake, 8'd255, 16'sd16384));
    send_item(command(MotorOff, 8'd0, -16'sd2));
    send_item(command(MotorCcw, 8'd0, 16'sd3));
    send_item(tick());
    send_item(command(MotorBrake, 8'd0, 16'sd0));

    // hold off until every result is back
    drain();

    while (items_sent < RandomItems) begin
      calm = ($urandom_range(0, 9) == 0);
      r    = $urandom_range(0, 99);
      if (r < 75) begin
        send_item(command(motor_cmd_e'($urandom_range(0, 3)), 8'($urandom),
                          random_timeout()));
        r = $urandom_range(0, 99);
        if (r < 60) burst = $urandom_range(0, 12);
        else if (r < 90) burst = $urandom_range(13, 80);
        else burst = $urandom_range(200, 600);
        repeat (burst) begin
          if (items_sent < RandomItems) send_item(tick());
        end
      end else begin
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 1)) send_item(tick());
          else send_item(command(motor_cmd_e'($urandom_range(0, 3)), 8'($urandom),
                                 16'($urandom)));
        end
      end
    end
    calm = 1'b0;

    drain();
    repeat (10) @(posedge clk);
    if (failures == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
